// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checksum unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with async active-low reset disable.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_PROP(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/inet_csum_pkg.sv =====
// ----------------------------------------------------------------------------
// inet_csum_pkg
// Types, constants and the ones'-complement adder for the checksum unit.
// ----------------------------------------------------------------------------
package inet_csum_pkg;

	localparam int WORD_W = 16;
	localparam int BYTE_W = 8;

	// item kind codes
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_WORD = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic  kind;
		word_t data;
		logic  seg_end;
		logic  last;
	} item_t;

	// 16-bit ones'-complement add with end-around carry
	function automatic word_t oc_add(input word_t a, input word_t b);
		logic [WORD_W:0] s;
		logic [WORD_W:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
		return f[WORD_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/inet_csum_ifs.sv =====
// ----------------------------------------------------------------------------
// inet_csum_ifs
// Valid/ready channel interfaces: item input, checksum output, config write.
// ----------------------------------------------------------------------------
interface inet_csum_in_if;
	import inet_csum_pkg::*;
	logic  valid;
	logic  ready;
	logic  kind;
	word_t data;
	logic  seg_end;
	logic  last;

	modport source (output valid, kind, data, seg_end, last, input ready);
	modport sink (input valid, kind, data, seg_end, last, output ready);
endinterface

interface inet_csum_out_if;
	import inet_csum_pkg::*;
	logic  valid;
	logic  ready;
	word_t checksum;

	modport source (output valid, checksum, input ready);
	modport sink (input valid, checksum, output ready);
endinterface

interface inet_csum_cfg_if;
	logic valid;
	logic ready;
	logic add_length;

	modport source (output valid, add_length, input ready);
	modport sink (input valid, add_length, output ready);
endinterface

// ===== hw/rtl/inet_csum_in_stage.sv =====
// ----------------------------------------------------------------------------
// inet_csum_in_stage
// Input register stage; holds one item beat until the accumulator takes it.
// ----------------------------------------------------------------------------
module inet_csum_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  inet_csum_pkg::item_t in_item,
	input  logic                 take,
	output logic                 valid_s1,
	output inet_csum_pkg::item_t item_s1
);
	import inet_csum_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/inet_csum_acc.sv =====
// ----------------------------------------------------------------------------
// inet_csum_acc
// Byte pairing, ones'-complement sum and length count, result register.
// ----------------------------------------------------------------------------
module inet_csum_acc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  inet_csum_pkg::item_t item_s1,
	output logic                 take,
	input  logic                 add_length,
	output logic                 res_valid,
	input  logic                 res_ready,
	output inet_csum_pkg::word_t res_checksum
);
	import inet_csum_pkg::*;

	word_t sum_q;
	word_t len_q;
	byte_t pbyte_q;
	logic  have_q;
	logic  res_valid_q;
	word_t checksum_q;

	word_t sum_a, sum_b, len_n, fin;
	byte_t pbyte_a;
	logic  pend_a;
	byte_t in_byte;

	// a last beat needs a free result slot; other beats never wait
	assign take = valid_s1 && (!item_s1.last || !res_valid_q || res_ready);
	assign in_byte = item_s1.data[BYTE_W-1:0];

	always_comb begin
		sum_a   = sum_q;
		pend_a  = have_q;
		pbyte_a = pbyte_q;
		len_n   = len_q;
		case (item_s1.kind)
			KIND_WORD: begin
				sum_a = oc_add(sum_q, item_s1.data);
			end
			KIND_BYTE: begin
				len_n = oc_add(len_q, word_t'(1));
				if (have_q) begin
					sum_a  = oc_add(sum_q, {pbyte_q, in_byte});
					pend_a = 1'b0;
				end else begin
					pend_a  = 1'b1;
					pbyte_a = in_byte;
				end
			end
			default: begin
				sum_a = sum_q;
			end
		endcase

		// segment close pads the odd byte as the high byte
		sum_b = sum_a;
		if ((item_s1.seg_end || item_s1.last) && pend_a) begin
			sum_b = oc_add(sum_a, {pbyte_a, {BYTE_W{1'b0}}});
		end

		fin = add_length ? oc_add(sum_b, len_n) : sum_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			len_q   <= '0;
			pbyte_q <= '0;
			have_q  <= 1'b0;
		end else if (take) begin
			if (item_s1.last) begin
				sum_q   <= '0;
				len_q   <= '0;
				pbyte_q <= '0;
				have_q  <= 1'b0;
			end else begin
				sum_q   <= sum_b;
				len_q   <= len_n;
				pbyte_q <= pbyte_a;
				have_q  <= pend_a && !item_s1.seg_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (take && item_s1.last) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			checksum_q <= ~fin;
		end
	end

	assign res_valid    = res_valid_q;
	assign res_checksum = checksum_q;

endmodule

// ===== hw/rtl/internet_checksum_pseudo_header_unit.sv =====
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header_unit
// Streaming Internet checksum with pseudo-header words and length add.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one beat per data byte (kind 0, byte in data[7:0]) or per
//            16-bit pseudo-header word (kind 1). seg_end pads an odd byte
//            as the high byte; last closes the message and yields a result.
//   result : one beat per message carrying the complemented 16-bit sum.
//   cfg    : add_length write; always ready, write only while idle.
//            Sampled when the last beat is summed.
// Path: a last beat is held in the input register, is summed when the
//   accumulator takes it, and its checksum then waits in the result
//   register until result takes it.
// Throughput: one beat per cycle unless a last beat waits for the slot;
//   the sum feedback loop is a chain of up to two 16-bit end-around-carry
//   adds, the path into the result register three, all combinational.
// Stall: while a checksum waits for result.ready, non-last beats keep
//   flowing; a last beat waits in the input register until the slot frees.
// Reset: arst_n clears sum, pending byte, byte count, add_length and both
//   valid flags; item.ready is high from the first cycle after reset.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header_unit (
	input logic             clk,
	input logic             arst_n,
	inet_csum_cfg_if.sink   cfg,
	inet_csum_in_if.sink    item,
	inet_csum_out_if.source result
);
	import inet_csum_pkg::*;

	logic  add_length_q;
	logic  valid_s1;
	item_t item_s1;
	item_t in_item;
	logic  take;

	// config register; single-bit, no handshake back-pressure
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_length_q <= 1'b0;
		end else if (cfg.valid) begin
			add_length_q <= cfg.add_length;
		end
	end

	// pack the input beat
	assign in_item = '{kind: item.kind, data: item.data,
		seg_end: item.seg_end, last: item.last};

	inet_csum_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// sum, pairing and the output register
	inet_csum_acc u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.take         (take),
		.add_length   (add_length_q),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.res_checksum (result.checksum)
	);

endmodule

// ===== hw/rtl/inet_csum_checker.sv =====
// ----------------------------------------------------------------------------
// inet_csum_checker
// Port-level assertions for the checksum unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module inet_csum_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input inet_csum_pkg::word_t result_checksum
);
	import inet_csum_pkg::*;

	logic res_stall;

	assign res_stall = result_valid && !result_ready;

	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, result_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_res_stable, clk, arst_n, res_stall, $stable(result_checksum), "checksum moved")
	`ASSERT_IMPLY(a_res_known, clk, arst_n, result_valid, !$isunknown(result_checksum), "checksum X")
	`ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !result_valid, item_ready, "input stalled")

endmodule

bind internet_checksum_pseudo_header_unit inet_csum_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_ready      (item.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_checksum (result.checksum)
);

// ===== verif/csum_checker.sv =====
// ----------------------------------------------------------------------------
// csum_checker
// Watches the config, item and result channels of the checksum unit, keeps
// its own running sum, and compares every result beat with the next
// expected checksum.
// ----------------------------------------------------------------------------
module csum_checker (
	input  logic        clk,
	input  logic        arst_n,
	inet_csum_cfg_if    cfg,
	inet_csum_in_if     item,
	inet_csum_out_if    result,
	output int unsigned fail_count,
	output int unsigned sums_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import inet_csum_pkg::*;

	word_t run_sum;
	byte_t held_byte;
	logic  byte_held;
	word_t byte_tally;
	logic  len_mode;
	word_t owed_q[$];

	// end-around-carry add
	function automatic word_t oc_plus(input word_t a, input word_t b);
		logic [WORD_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[WORD_W-1:0] + word_t'(t[WORD_W]);
	endfunction

	task automatic clear_sum();
		run_sum = '0;
		held_byte = '0;
		byte_held = 1'b0;
		byte_tally = '0;
	endtask

	task automatic take_beat(input item_t b);
		word_t total;
		if (b.kind == KIND_WORD) begin
			run_sum = oc_plus(run_sum, b.data);
		end else begin
			byte_tally = oc_plus(byte_tally, 16'd1);
			if (byte_held) begin
				run_sum = oc_plus(run_sum, {held_byte, b.data[BYTE_W-1:0]});
				held_byte = '0;
				byte_held = 1'b0;
			end else begin
				held_byte = b.data[BYTE_W-1:0];
				byte_held = 1'b1;
			end
		end
		// segment close after the beat's own byte
		if ((b.seg_end || b.last) && byte_held) begin
			run_sum = oc_plus(run_sum, {held_byte, 8'h00});
			held_byte = '0;
			byte_held = 1'b0;
		end
		if (b.last) begin
			total = run_sum;
			if (len_mode)
				total = oc_plus(total, byte_tally);
			owed_q.push_back(~total);
			clear_sum();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t beat;
		word_t want;
		if (!arst_n) begin
			clear_sum();
			len_mode = 1'b0;
			owed_q.delete();
			fail_count = 0;
			sums_owed = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (owed_q.size() == 0) begin
					$error("checksum beat with no expected value: actual %04h",
						result.checksum);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					if (result.checksum !== want) begin
						$error("checksum mismatch: expected %04h, actual %04h",
							want, result.checksum);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready) begin
				beat.kind = item.kind;
				beat.data = item.data;
				beat.seg_end = item.seg_end;
				beat.last = item.last;
				take_beat(beat);
			end
			if (cfg.valid && cfg.ready)
				len_mode = cfg.add_length;
			sums_owed = owed_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the checksum unit with directed and random messages of data bytes
// and pseudo-header words under random idling on both sides, and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import inet_csum_pkg::*;

	localparam int unsigned HALF_PERIOD   = 10;
	localparam int unsigned RESET_CYCLES  = 3;
	localparam int unsigned MAX_GAP       = 10;
	localparam int unsigned HOLD_CYCLES   = 80;     // long result-side hold-off
	localparam int unsigned SETTLE_CYCLES = 4;      // settle wait after a drain, before a write
	localparam int unsigned RANDOM_BEATS  = 900;
	localparam int unsigned CYCLE_LIMIT   = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	inet_csum_cfg_if cfg_ch ();
	inet_csum_in_if  item_ch ();
	inet_csum_out_if result_ch ();

	int unsigned fail_count;
	int unsigned sums_owed;

	internet_checksum_pseudo_header_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	csum_checker checker_u (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.item       (item_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.sums_owed  (sums_owed)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Watchdog: a hung handshake or a missing checksum ends up here.
	int unsigned cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Hold-off handshake between stimulus and the result side: the stimulus
	// bumps hold_req, the result side notices it between beats.
	int unsigned hold_req = 0;
	int unsigned hold_seen = 0;

	// ------------------------------------------------------------------
	// Result side. Before each beat it draws a random stall, holds off long
	// when the stimulus bumps hold_req, or keeps ready high in brisk stretches.
	// ------------------------------------------------------------------
	initial begin
		int unsigned pause;
		int unsigned beats_taken;
		bit rx_brisk;
		beats_taken = 0;
		rx_brisk = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				pause = HOLD_CYCLES;
			end else if (rx_brisk) begin
				pause = 0;
			end else begin
				pause = $urandom_range(0, MAX_GAP);
			end
			if (pause > 0) begin
				result_ch.ready = 1'b0;
				repeat (pause) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
			beats_taken++;
			if (beats_taken % 16 == 0)
				rx_brisk = ($urandom_range(0, 3) == 0);
		end
	end

	// ------------------------------------------------------------------
	// Item side helpers
	// ------------------------------------------------------------------

	// One item beat: idle for the gap, offer it, wait for the handshake.
	// valid drops right after; the next call raises it again in the same step
	// when its gap is zero, so back-to-back beats see valid steady high.
	task automatic drive_beat(input logic k, input word_t d, input logic se,
		input logic lst, input int unsigned gap);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.kind = k;
		item_ch.data = d;
		item_ch.seg_end = se;
		item_ch.last = lst;
		item_ch.valid = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		item_ch.valid = 1'b0;
	endtask

	task automatic dir_beat(input logic k, input word_t d, input logic se,
		input logic lst);
		drive_beat(k, d, se, lst, $urandom_range(0, MAX_GAP));
	endtask

	// Wait until every predicted checksum has been taken.
	task automatic wait_drained();
		while (sums_owed != 0) @(negedge clk);
	endtask

	// Register write, only with the unit idle: drained, then a settle wait
	// so an accepted non-last beat has left the input register.
	task automatic set_add_length(input logic v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_ch.add_length = v;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Random data word, biased toward the all-zero and all-one extremes.
	function automatic word_t pick_data();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 16'hffff;
		else if (r == 1)
			return 16'h0000;
		else
			return word_t'($urandom);
	endfunction

	// One message of n beats: a random mix of bytes and words, random
	// segment closes, last on the final beat. Byte beats carry random high
	// bits too, which the unit must ignore.
	task automatic send_message(input int unsigned n, input bit brisk);
		int unsigned word_pct;
		int unsigned seg_pct;
		logic k;
		logic se;
		for (int unsigned i = 0; i < n; i++) begin
			word_pct = $urandom_range(0, 40);
			seg_pct = $urandom_range(0, 30);
			k = ($urandom_range(0, 99) < word_pct) ? KIND_WORD : KIND_BYTE;
			se = ($urandom_range(0, 99) < seg_pct);
			drive_beat(k, pick_data(), se, (i == n - 1),
				brisk ? 0 : $urandom_range(0, MAX_GAP));
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int unsigned beats_sent;
		int unsigned phase_goal;
		int unsigned n;
		bit drained_once;
		beats_sent = 0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_BYTE;
		item_ch.data = '0;
		item_ch.seg_end = 1'b0;
		item_ch.last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.add_length = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed, add_length at its reset value 0 ---
		// byte beats with garbage in the high bits
		dir_beat(KIND_BYTE, 16'hff00, 1'b0, 1'b0);
		dir_beat(KIND_BYTE, 16'h00ff, 1'b0, 1'b1);
		// words forcing end-around carries
		dir_beat(KIND_WORD, 16'hffff, 1'b0, 1'b0);
		dir_beat(KIND_WORD, 16'hffff, 1'b0, 1'b0);
		dir_beat(KIND_WORD, 16'h0001, 1'b0, 1'b1);
		// word slipped in while a byte is pending; the byte pairs later
		dir_beat(KIND_BYTE, 16'h0012, 1'b0, 1'b0);
		dir_beat(KIND_WORD, 16'habcd, 1'b0, 1'b0);
		dir_beat(KIND_BYTE, 16'hff34, 1'b0, 1'b1);
		// odd segments padded as high bytes
		dir_beat(KIND_BYTE, 16'h005a, 1'b1, 1'b0);
		dir_beat(KIND_BYTE, 16'h00a5, 1'b1, 1'b0);
		dir_beat(KIND_WORD, 16'h0000, 1'b0, 1'b1);
		// lone byte on the last beat: byte first, then the pad
		dir_beat(KIND_BYTE, 16'h80c3, 1'b0, 1'b1);
		// empty-ish message: one zero word
		dir_beat(KIND_WORD, 16'h0000, 1'b1, 1'b1);
		// all-ones pair
		dir_beat(KIND_BYTE, 16'h00ff, 1'b0, 1'b0);
		dir_beat(KIND_BYTE, 16'h00ff, 1'b0, 1'b1);

		// --- directed, length added ---
		set_add_length(1'b1);
		dir_beat(KIND_WORD, 16'hc0a8, 1'b0, 1'b0);
		dir_beat(KIND_WORD, 16'h0011, 1'b0, 1'b0);
		dir_beat(KIND_BYTE, 16'h0001, 1'b0, 1'b0);
		dir_beat(KIND_BYTE, 16'h0002, 1'b1, 1'b0);
		dir_beat(KIND_BYTE, 16'h0003, 1'b0, 1'b1);
		dir_beat(KIND_BYTE, 16'h00ff, 1'b0, 1'b1);
		dir_beat(KIND_WORD, 16'hffff, 1'b0, 1'b1);

		// --- random phases, register setting changed between them ---
		drained_once = 1'b0;
		for (int unsigned phase = 0; phase < 4; phase++) begin
			if (phase == 3)
				set_add_length(logic'($urandom_range(0, 1)));
			else
				set_add_length(phase[0] ? 1'b0 : 1'b1);

			if (phase == 1) begin
				// Result side stalls long while short messages arrive
				// back to back: the result slot and the input register fill
				// and the unit has to hold off the item side.
				hold_req++;
				for (int unsigned m = 0; m < 10; m++) begin
					n = $urandom_range(1, 3);
					send_message(n, 1'b1);
					beats_sent += n;
				end
			end

			phase_goal = (phase + 1) * RANDOM_BEATS / 4;
			while (beats_sent < phase_goal) begin
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(25, 64);
				else
					n = $urandom_range(1, 16);
				send_message(n, ($urandom_range(0, 4) == 0));
				beats_sent += n;
				// item side goes quiet until every checksum is back
				if (phase == 2 && !drained_once &&
					beats_sent > phase_goal - RANDOM_BEATS / 8) begin
					wait_drained();
					drained_once = 1'b1;
				end
			end
		end

		// drain, let the pipe settle, then the verdict
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
